### hw/rtl/ede_pkg.sv
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared opcodes, widths and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ede_pkg;

   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int DIST_W   = 6;

   localparam logic [OPCODE_W-1:0] OP_APPEND_FIRST  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND_SECOND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_COMPUTE       = 2'd2;

   typedef struct packed {
      logic load_first;
      logic load_second;
      logic begin_run;
      logic init_wr;
      logic row_start;
      logic cell_wr;
      logic finish;
   } ede_cmd_type;

   typedef struct packed {
      logic len_empty;
      logic j_last;
      logic i_last;
   } ede_status_type;

endpackage

### hw/rtl/ede_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ede_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/ede_dpath.sv
// ----------------------------------------------------------------------------
// Edit distance datapath
// String stores, lengths, the cost row and the cell update of the table.
// ----------------------------------------------------------------------------
module ede_dpath #(
   parameter int MAX_LEN = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ede_pkg::ede_cmd_type        cmd,
   output ede_pkg::ede_status_type     status,
   input  logic [ede_pkg::CHAR_W-1:0]  char_value,
   output logic [ede_pkg::DIST_W-1:0]  rsp_distance,
   output logic                        rsp_overflow
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   logic [LW-1:0] first_len_ff, first_len_in;
   logic [LW-1:0] second_len_ff, second_len_in;
   logic          overflow_ff, overflow_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] j_ff, j_in;
   logic [LW-1:0] diag_ff, diag_in;
   logic [LW-1:0] left_ff, left_in;
   logic [ede_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic [ede_pkg::CHAR_W-1:0] a_byte, b_byte;
   logic [LW-1:0] above;
   logic [AW-1:0] j_addr;
   logic [AW-1:0] i_addr;
   logic          first_we, second_we, cost_we;
   logic [LW-1:0] cost_wdata;
   logic [LW:0]   cand_up, cand_left, cand_diag, best_wide;
   logic [LW-1:0] result;
   logic          first_full, second_full;

   assign first_full  = (first_len_ff == LW'(MAX_LEN));
   assign second_full = (second_len_ff == LW'(MAX_LEN));
   assign first_we    = cmd.load_first && !first_full;
   assign second_we   = cmd.load_second && !second_full;
   assign i_addr      = AW'(i_ff - LW'(1));
   assign j_addr      = AW'(j_ff - LW'(1));
   assign cost_we     = cmd.init_wr || cmd.cell_wr;
   assign cost_wdata  = cmd.init_wr ? j_ff : best_wide[LW-1:0];

   ede_ram #(.WIDTH(ede_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_first (
      .clock (clock),
      .we    (first_we),
      .waddr (first_len_ff[AW-1:0]),
      .wdata (char_value),
      .raddr (i_addr),
      .rdata (a_byte)
   );

   ede_ram #(.WIDTH(ede_pkg::CHAR_W), .DEPTH(MAX_LEN)) u_second (
      .clock (clock),
      .we    (second_we),
      .waddr (second_len_ff[AW-1:0]),
      .wdata (char_value),
      .raddr (j_addr),
      .rdata (b_byte)
   );

   ede_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_cost (
      .clock (clock),
      .we    (cost_we),
      .waddr (j_addr),
      .wdata (cost_wdata),
      .raddr (j_addr),
      .rdata (above)
   );

   always_comb begin
      cand_up   = (LW+1)'(above) + (LW+1)'(1);
      cand_left = (LW+1)'(left_ff) + (LW+1)'(1);
      cand_diag = (LW+1)'(diag_ff) + ((a_byte == b_byte) ? (LW+1)'(0) : (LW+1)'(1));
      best_wide = (cand_left < cand_up) ? cand_left : cand_up;
      if (cand_diag < best_wide) begin
         best_wide = cand_diag;
      end
   end

   always_comb begin
      if (first_len_ff == '0) begin
         result = second_len_ff;
      end else if (second_len_ff == '0) begin
         result = first_len_ff;
      end else begin
         result = left_ff;
      end
   end

   assign status.len_empty = (first_len_ff == '0) || (second_len_ff == '0);
   assign status.j_last    = (j_ff == second_len_ff);
   assign status.i_last    = (i_ff == first_len_ff);

   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      overflow_in   = overflow_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      diag_in       = diag_ff;
      left_in       = left_ff;
      dist_in       = dist_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      if (cmd.load_first) begin
         if (first_full) begin
            overflow_in = 1'b1;
         end else begin
            first_len_in = first_len_ff + LW'(1);
         end
      end
      if (cmd.load_second) begin
         if (second_full) begin
            overflow_in = 1'b1;
         end else begin
            second_len_in = second_len_ff + LW'(1);
         end
      end
      if (cmd.begin_run) begin
         i_in = LW'(1);
         j_in = LW'(1);
      end
      if (cmd.init_wr) begin
         j_in = status.j_last ? LW'(1) : j_ff + LW'(1);
      end
      if (cmd.row_start) begin
         diag_in = i_ff - LW'(1);
         left_in = i_ff;
      end
      if (cmd.cell_wr) begin
         left_in = best_wide[LW-1:0];
         diag_in = above;
         if (status.j_last) begin
            j_in = LW'(1);
            if (!status.i_last) begin
               i_in = i_ff + LW'(1);
            end
         end else begin
            j_in = j_ff + LW'(1);
         end
      end
      if (cmd.finish) begin
         if ((LW+ede_pkg::DIST_W)'(result) > (LW+ede_pkg::DIST_W)'(63)) begin
            dist_in = {ede_pkg::DIST_W{1'b1}};
         end else begin
            dist_in = ede_pkg::DIST_W'(result);
         end
         rsp_ovf_in    = overflow_ff;
         first_len_in  = '0;
         second_len_in = '0;
         overflow_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_len_ff  <= '0;
         second_len_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         overflow_ff   <= overflow_in;
      end
      i_ff       <= i_in;
      j_ff       <= j_in;
      diag_ff    <= diag_in;
      left_ff    <= left_in;
      dist_ff    <= dist_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_distance = dist_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

### hw/rtl/ede_ctrl.sv
// ----------------------------------------------------------------------------
// Edit distance controller
// Accepts beats and sequences the table fill, each cell in a read state and a write state.
// ----------------------------------------------------------------------------
module ede_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ede_pkg::OPCODE_W-1:0]  opcode,
   input  ede_pkg::ede_status_type       status,
   output ede_pkg::ede_cmd_type          cmd,
   output logic                          busy,
   output logic                          rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW,
      ST_CELL_RD,
      ST_CELL_WR,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode)
                  ede_pkg::OP_APPEND_FIRST:  cmd.load_first  = 1'b1;
                  ede_pkg::OP_APPEND_SECOND: cmd.load_second = 1'b1;
                  ede_pkg::OP_COMPUTE: begin
                     cmd.begin_run = 1'b1;
                     state_in      = status.len_empty ? ST_DONE : ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.j_last) begin
               state_in = ST_ROW;
            end
         end
         ST_ROW: begin
            cmd.row_start = 1'b1;
            state_in      = ST_CELL_RD;
         end
         ST_CELL_RD: begin
            state_in = ST_CELL_WR;
         end
         ST_CELL_WR: begin
            cmd.cell_wr = 1'b1;
            if (!status.j_last) begin
               state_in = ST_CELL_RD;
            end else if (status.i_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ROW;
            end
         end
         ST_DONE: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_DONE))
      else $error("Result strobe without a finished run.");

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("Result strobe held longer than one cycle.");

   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == ede_pkg::OP_COMPUTE) |=> busy)
      else $error("Compute beat did not make the engine busy.");

endmodule

### hw/rtl/edit_distance_engine.sv
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance between two loaded byte strings, unit costs.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   start, busy          req_opcode, req_char_value
//  response  rsp_valid (strobe)   rsp_distance, rsp_overflow
//
// An append beat leaves busy low.
// A compute beat holds busy high for the whole run, also when either
// string is empty; each table cell is a read of the cost row RAM, then
// an update and write back.
// The result strobe comes in the same cycle as busy falls, and the receiver
// cannot stall it. Reset clears both lengths and the overflow flag.
// ----------------------------------------------------------------------------
module edit_distance_engine #(
   parameter int MAX_LEN = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ede_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [ede_pkg::CHAR_W-1:0]    req_char_value,
   output logic                          rsp_valid,
   output logic [ede_pkg::DIST_W-1:0]    rsp_distance,
   output logic                          rsp_overflow
);

   ede_pkg::ede_cmd_type    cmd;
   ede_pkg::ede_status_type status;

   ede_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_opcode),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ede_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .char_value   (req_char_value),
      .rsp_distance (rsp_distance),
      .rsp_overflow (rsp_overflow)
   );

endmodule
